/* src/slt_pkg.sv */
// ----------------------------------------------------------------------------
// slt_pkg
// Shared types, character codes and the per-byte lexer step of the shell
// line tokenizer.
// ----------------------------------------------------------------------------
`default_nettype none

package slt_pkg;

  // Character codes the lexer reacts to
  localparam logic [7:0] CH_LT     = 8'h3C;  // '<'
  localparam logic [7:0] CH_GT     = 8'h3E;  // '>'
  localparam logic [7:0] CH_PIPE   = 8'h7C;  // '|'
  localparam logic [7:0] CH_SEMI   = 8'h3B;  // ';'
  localparam logic [7:0] CH_LPAREN = 8'h28;  // '('
  localparam logic [7:0] CH_RPAREN = 8'h29;  // ')'
  localparam logic [7:0] CH_BSLASH = 8'h5C;  // '\'
  localparam logic [7:0] CH_SQUOTE = 8'h27;  // single quote
  localparam logic [7:0] CH_DQUOTE = 8'h22;  // double quote
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_NUL    = 8'h00;

  // Quote mode codes (code 3 behaves as double)
  localparam logic [1:0] QM_NONE   = 2'd0;
  localparam logic [1:0] QM_SINGLE = 2'd1;
  localparam logic [1:0] QM_DOUBLE = 2'd2;

  // Held redirect codes (code 3 behaves as '>')
  localparam logic [1:0] HELD_NONE = 2'd0;
  localparam logic [1:0] HELD_LT   = 2'd1;
  localparam logic [1:0] HELD_GT   = 2'd2;

  // Input op codes
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_EOL  = 1'b1;

  // Result queue depth
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [1:0] quote_mode;
    logic       word_open;
    logic       escape_next;
    logic [1:0] held_redirect;
  } lex_state_t;

  localparam lex_state_t LEX_RESET = '{
    quote_mode:    QM_NONE,
    word_open:     1'b0,
    escape_next:   1'b0,
    held_redirect: HELD_NONE
  };

  typedef struct packed {
    logic [7:0] char_out;
    logic       has_char;
    logic       token_end;
    logic       line_end;
    logic       error;
  } token_t;

  // Up to two tokens pushed into the result queue per item
  typedef struct packed {
    logic [1:0]      count;
    token_t [1:0]    tok;
  } token_push_t;

  typedef struct packed {
    lex_state_t  state;
    token_push_t push;
  } lex_result_t;

  function automatic token_t mk_token(logic [7:0] ch, logic has, logic te,
                                      logic le, logic er);
    token_t t;
    t.char_out  = ch;
    t.has_char  = has;
    t.token_end = te;
    t.line_end  = le;
    t.error     = er;
    return t;
  endfunction

  // One lexer step: next state and the tokens caused by one item
  function automatic lex_result_t lex_next(lex_state_t s, logic op, logic [7:0] c);
    lex_result_t r;
    logic [7:0]  hc;
    logic        done;
    r.state      = s;
    r.push.count = 2'd0;
    r.push.tok   = '0;
    done         = 1'b0;
    hc = (s.held_redirect == HELD_LT) ? CH_LT : CH_GT;

    if (op == OP_EOL) begin
      // flush held operator or open word, then close the line
      if (s.held_redirect != HELD_NONE) begin
        r.push.tok[0] = mk_token(hc, 1'b1, 1'b1, 1'b0, 1'b0);
        r.push.count  = 2'd1;
      end else if (s.word_open) begin
        r.push.tok[0] = mk_token(CH_NUL, 1'b0, 1'b1, 1'b0, 1'b0);
        r.push.count  = 2'd1;
      end
      r.push.tok[r.push.count[0]] = mk_token(CH_NUL, 1'b0, 1'b0, 1'b1,
                                             s.quote_mode != QM_NONE);
      r.push.count = r.push.count + 2'd1;
      r.state      = LEX_RESET;
    end else if (c != CH_NUL) begin
      if (s.escape_next) begin
        // literal byte after backslash
        r.state.escape_next = 1'b0;
        r.push.tok[0]       = mk_token(c, 1'b1, 1'b0, 1'b0, 1'b0);
        r.push.count        = 2'd1;
        r.state.word_open   = 1'b1;
        done                = 1'b1;
      end else if (s.held_redirect != HELD_NONE) begin
        r.state.held_redirect = HELD_NONE;
        if (c == hc) begin
          // doubled operator
          r.push.tok[0] = mk_token(hc, 1'b1, 1'b0, 1'b0, 1'b0);
          r.push.tok[1] = mk_token(hc, 1'b1, 1'b1, 1'b0, 1'b0);
          r.push.count  = 2'd2;
          done          = 1'b1;
        end else begin
          r.push.tok[0] = mk_token(hc, 1'b1, 1'b1, 1'b0, 1'b0);
          r.push.count  = 2'd1;
        end
      end

      if (!done) begin
        if (r.state.quote_mode == QM_NONE) begin
          if (c == CH_SPACE || c == CH_TAB || c == CH_NL ||
              c == CH_LT || c == CH_GT || c == CH_PIPE || c == CH_SEMI ||
              c == CH_LPAREN || c == CH_RPAREN) begin
            // delimiter: close any open word first
            if (r.state.word_open) begin
              r.push.tok[r.push.count[0]] = mk_token(CH_NUL, 1'b0, 1'b1,
                                                     1'b0, 1'b0);
              r.push.count      = r.push.count + 2'd1;
              r.state.word_open = 1'b0;
            end
            if (c == CH_LT || c == CH_GT) begin
              r.state.held_redirect = (c == CH_LT) ? HELD_LT : HELD_GT;
            end else if (c == CH_PIPE || c == CH_SEMI ||
                         c == CH_LPAREN || c == CH_RPAREN) begin
              r.push.tok[r.push.count[0]] = mk_token(c, 1'b1, 1'b1, 1'b0, 1'b0);
              r.push.count = r.push.count + 2'd1;
            end
          end else begin
            r.push.tok[r.push.count[0]] = mk_token(c, 1'b1, 1'b0, 1'b0, 1'b0);
            r.push.count      = r.push.count + 2'd1;
            r.state.word_open = 1'b1;
            if (c == CH_BSLASH) begin
              r.state.escape_next = 1'b1;
            end else if (c == CH_SQUOTE) begin
              r.state.quote_mode = QM_SINGLE;
            end else if (c == CH_DQUOTE) begin
              r.state.quote_mode = QM_DOUBLE;
            end
          end
        end else if (r.state.quote_mode == QM_SINGLE) begin
          r.push.tok[r.push.count[0]] = mk_token(c, 1'b1, 1'b0, 1'b0, 1'b0);
          r.push.count      = r.push.count + 2'd1;
          r.state.word_open = 1'b1;
          if (c == CH_SQUOTE) begin
            r.state.quote_mode = QM_NONE;
          end
        end else begin
          r.push.tok[r.push.count[0]] = mk_token(c, 1'b1, 1'b0, 1'b0, 1'b0);
          r.push.count      = r.push.count + 2'd1;
          r.state.word_open = 1'b1;
          if (c == CH_BSLASH) begin
            r.state.escape_next = 1'b1;
          end else if (c == CH_DQUOTE) begin
            r.state.quote_mode = QM_NONE;
          end
        end
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* src/slt_lex.sv */
// ----------------------------------------------------------------------------
// slt_lex
// Input register, lexer state and the per-byte step that turns one
// registered item into zero, one or two tokens.
// ----------------------------------------------------------------------------
`default_nettype none

module slt_lex (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic                 in_op,
  input  wire logic [7:0]           in_char,
  input  wire logic                 space,
  output slt_pkg::token_push_t      push
);

  logic                  item_valid;
  logic                  item_op;
  logic [7:0]            item_char;
  slt_pkg::lex_state_t   state;
  slt_pkg::lex_result_t  step;
  logic                  take_item;

  // item is consumed once the queue has room for two tokens
  assign take_item = item_valid && space;
  assign in_ready  = !item_valid || take_item;

  assign step = slt_pkg::lex_next(state, item_op, item_char);

  always_comb begin
    push = step.push;
    if (!take_item) begin
      push.count = 2'd0;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      item_op   <= in_op;
      item_char <= in_char;
    end
  end

  // lexer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= slt_pkg::LEX_RESET;
    end else if (take_item) begin
      state <= step.state;
    end
  end

`ifndef SYNTHESIS
  // line end always returns the lexer to its reset state
  a_eol_reset: assert property (@(posedge clk) disable iff (rst)
    take_item && item_op == slt_pkg::OP_EOL |=> state == slt_pkg::LEX_RESET)
    else $error("lexer state not cleared after line end");

  // an escape pending means the backslash opened or extended a word
  a_escape_word: assert property (@(posedge clk) disable iff (rst)
    state.escape_next |-> state.word_open)
    else $error("escape pending without open word");

  // a held redirect is only taken with no word open
  a_held_closed: assert property (@(posedge clk) disable iff (rst)
    state.held_redirect != slt_pkg::HELD_NONE |-> !state.word_open &&
      !state.escape_next && state.quote_mode == slt_pkg::QM_NONE)
    else $error("held redirect with open word or quote");
`endif

endmodule

`default_nettype wire

/* src/slt_out_fifo.sv */
// ----------------------------------------------------------------------------
// slt_out_fifo
// Small result queue: takes up to two tokens per cycle from the lexer and
// hands one token per transfer to the output side.
// ----------------------------------------------------------------------------
`default_nettype none

module slt_out_fifo (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire slt_pkg::token_push_t push,
  output logic                      space,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output slt_pkg::token_t           out_tok
);

  slt_pkg::token_t                    mem [slt_pkg::QDEPTH];
  logic [slt_pkg::QPTR_W-1:0]         wr_ptr;
  logic [slt_pkg::QPTR_W-1:0]         rd_ptr;
  logic [slt_pkg::QCNT_W-1:0]         count;
  logic [slt_pkg::QCNT_W-1:0]         count_next;
  logic                               pop;

  // room for a full two-token push
  assign space     = count <= slt_pkg::QCNT_W'(slt_pkg::QDEPTH - 2);
  assign out_valid = count != '0;
  assign pop       = out_valid && out_ready;
  assign out_tok   = mem[rd_ptr];

  assign count_next = count + slt_pkg::QCNT_W'(push.count)
                    - slt_pkg::QCNT_W'(pop);

  // token storage
  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem[wr_ptr] <= push.tok[0];
    end
    if (push.count == 2'd2) begin
      mem[wr_ptr + slt_pkg::QPTR_W'(1)] <= push.tok[1];
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + slt_pkg::QPTR_W'(push.count);
      if (pop) begin
        rd_ptr <= rd_ptr + slt_pkg::QPTR_W'(1);
      end
      count <= count_next;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= slt_pkg::QCNT_W'(slt_pkg::QDEPTH))
    else $error("result queue overflow");

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    push.count != 2'd0 |-> space)
    else $error("push without room in result queue");

  a_count_track: assert property (@(posedge clk) disable iff (rst)
    push.count == 2'd0 && !pop |=> count == $past(count))
    else $error("fill count moved without push or pop");
`endif

endmodule

`default_nettype wire

/* src/shell_line_tokenizer.sv */
// ----------------------------------------------------------------------------
// shell_line_tokenizer
// Streaming lexer for shell command lines: bytes in, token stream out.
// ----------------------------------------------------------------------------
// One item is accepted per cycle on the slave side while the queue has room
// for two tokens. Each item sits in the input register, where the lexer step
// runs, and its tokens (none for a zero byte or a delimiter with no word to
// close, one for most bytes, two for a doubled or flushed redirect and for an
// operator or line end that closes a word) go into a four-entry result queue.
// The master side drains one token per cycle while m_tready is high, so the
// sustained input rate is one item per cycle while items give at most one
// token each, and follows the output rate otherwise. m_tlast marks the
// line-end token; an error flag on it means a quote left open, a bad line.
// ----------------------------------------------------------------------------
`default_nettype none

module shell_line_tokenizer (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_tvalid,
  output logic            s_tready,
  input  wire logic [7:0] s_tdata,   // [7:0] char_in
  input  wire logic       s_tuser,   // [0] op
  output logic            m_tvalid,
  input  wire logic       m_tready,
  output logic [7:0]      m_tdata,   // [7:0] char_out
  output logic [2:0]      m_tuser,   // [0] has_char, [1] token_end, [2] error
  output logic            m_tlast    // line_end
);

  slt_pkg::token_push_t push;
  slt_pkg::token_t      out_tok;
  logic                 space;

  slt_lex u_lex (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_op    (s_tuser),
    .in_char  (s_tdata),
    .space    (space),
    .push     (push)
  );

  slt_out_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .space     (space),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_tok   (out_tok)
  );

  // output field mapping
  assign m_tdata = out_tok.char_out;
  assign m_tuser = {out_tok.error, out_tok.token_end, out_tok.has_char};
  assign m_tlast = out_tok.line_end;

endmodule

`default_nettype wire

/* dv/slt_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slt_checker
// Watches both stream channels of the shell line tokenizer, predicts the
// token stream of every accepted byte or line end, and compares each output
// transfer field by field against the oldest predicted token.
// ----------------------------------------------------------------------------

module slt_checker (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_tvalid,
  input  wire logic       s_tready,
  input  wire logic [7:0] s_tdata,   // [7:0] char_in
  input  wire logic       s_tuser,   // [0] op
  input  wire logic       m_tvalid,
  input  wire logic       m_tready,
  input  wire logic [7:0] m_tdata,   // [7:0] char_out
  input  wire logic [2:0] m_tuser,   // [0] has_char, [1] token_end, [2] error
  input  wire logic       m_tlast,   // line_end
  input  wire logic       end_of_test,
  output int              fail_count,
  output int              pending,
  output int              tokens_seen,
  output int              error_lines
);

  typedef struct packed {
    logic [7:0] ch;
    logic       has;
    logic       te;
    logic       le;
    logic       er;
  } lex_token_t;

  // Predicted lexer state
  logic [1:0] qmode   = slt_pkg::QM_NONE;
  logic       in_word = 1'b0;
  logic       esc     = 1'b0;
  logic [1:0] held    = slt_pkg::HELD_NONE;

  lex_token_t expected_tokens[$];
  int         mismatches    = 0;
  int         tok_cnt       = 0;
  int         err_cnt       = 0;
  logic       leftover_done = 1'b0;
  lex_token_t exp_tok;

  task automatic report_mismatch(input string msg);
    $display("%0t ERROR: %s", $time, msg);
    mismatches++;
  endtask

  task automatic push_token(input logic [7:0] ch, input logic has, input logic te,
                            input logic le, input logic er);
    lex_token_t t;
    t.ch  = ch;
    t.has = has;
    t.te  = te;
    t.le  = le;
    t.er  = er;
    expected_tokens.push_back(t);
  endtask

  task automatic word_char(input logic [7:0] c);
    push_token(c, 1'b1, 1'b0, 1'b0, 1'b0);
    in_word = 1'b1;
  endtask

  task automatic close_word();
    if (in_word) begin
      push_token(slt_pkg::CH_NUL, 1'b0, 1'b1, 1'b0, 1'b0);
      in_word = 1'b0;
    end
  endtask

  // Tokens caused by one accepted item, and the state update
  task automatic predict_tokens(input logic op, input logic [7:0] c);
    logic [7:0] hc;
    logic       doubled;
    hc      = (held == slt_pkg::HELD_LT) ? slt_pkg::CH_LT : slt_pkg::CH_GT;
    doubled = 1'b0;
    if (op == slt_pkg::OP_EOL) begin
      // flush held operator or open word, then mark the line end
      if (held != slt_pkg::HELD_NONE) begin
        push_token(hc, 1'b1, 1'b1, 1'b0, 1'b0);
      end else begin
        close_word();
      end
      push_token(slt_pkg::CH_NUL, 1'b0, 1'b0, 1'b1, qmode != slt_pkg::QM_NONE);
      qmode   = slt_pkg::QM_NONE;
      in_word = 1'b0;
      esc     = 1'b0;
      held    = slt_pkg::HELD_NONE;
    end else if (c != slt_pkg::CH_NUL) begin
      if (esc) begin
        // byte after a backslash is taken as is
        esc = 1'b0;
        word_char(c);
      end else begin
        if (held != slt_pkg::HELD_NONE) begin
          held = slt_pkg::HELD_NONE;
          if (c == hc) begin
            push_token(hc, 1'b1, 1'b0, 1'b0, 1'b0);
            push_token(hc, 1'b1, 1'b1, 1'b0, 1'b0);
            doubled = 1'b1;
          end else begin
            push_token(hc, 1'b1, 1'b1, 1'b0, 1'b0);
          end
        end
        if (!doubled) begin
          if (qmode == slt_pkg::QM_NONE) begin
            if (c == slt_pkg::CH_SPACE || c == slt_pkg::CH_TAB ||
                c == slt_pkg::CH_NL) begin
              close_word();
            end else if (c == slt_pkg::CH_LT || c == slt_pkg::CH_GT) begin
              close_word();
              held = (c == slt_pkg::CH_LT) ? slt_pkg::HELD_LT : slt_pkg::HELD_GT;
            end else if (c == slt_pkg::CH_PIPE || c == slt_pkg::CH_SEMI ||
                         c == slt_pkg::CH_LPAREN || c == slt_pkg::CH_RPAREN) begin
              close_word();
              push_token(c, 1'b1, 1'b1, 1'b0, 1'b0);
            end else begin
              word_char(c);
              if (c == slt_pkg::CH_BSLASH) begin
                esc = 1'b1;
              end else if (c == slt_pkg::CH_SQUOTE) begin
                qmode = slt_pkg::QM_SINGLE;
              end else if (c == slt_pkg::CH_DQUOTE) begin
                qmode = slt_pkg::QM_DOUBLE;
              end
            end
          end else if (qmode == slt_pkg::QM_SINGLE) begin
            word_char(c);
            if (c == slt_pkg::CH_SQUOTE) begin
              qmode = slt_pkg::QM_NONE;
            end
          end else begin
            word_char(c);
            if (c == slt_pkg::CH_BSLASH) begin
              esc = 1'b1;
            end else if (c == slt_pkg::CH_DQUOTE) begin
              qmode = slt_pkg::QM_NONE;
            end
          end
        end
      end
    end
  endtask

  // Monitor: inputs are predicted, outputs compared, all at the rising edge
  always @(posedge clk) begin
    if (rst) begin
      qmode   = slt_pkg::QM_NONE;
      in_word = 1'b0;
      esc     = 1'b0;
      held    = slt_pkg::HELD_NONE;
      expected_tokens.delete();
    end else begin
      if (s_tvalid && s_tready) begin
        predict_tokens(s_tuser, s_tdata);
      end
      if (m_tvalid && m_tready) begin
        tok_cnt++;
        if (expected_tokens.size() == 0) begin
          report_mismatch($sformatf(
            "token with nothing predicted: data %02h user %03b last %0b",
            m_tdata, m_tuser, m_tlast));
        end else begin
          exp_tok = expected_tokens.pop_front();
          if (m_tdata !== exp_tok.ch)
            report_mismatch($sformatf("char_out %02h, predicted %02h", m_tdata, exp_tok.ch));
          if (m_tuser[0] !== exp_tok.has)
            report_mismatch($sformatf("has_char %0b, predicted %0b", m_tuser[0], exp_tok.has));
          if (m_tuser[1] !== exp_tok.te)
            report_mismatch($sformatf("token_end %0b, predicted %0b", m_tuser[1], exp_tok.te));
          if (m_tlast !== exp_tok.le)
            report_mismatch($sformatf("line_end %0b, predicted %0b", m_tlast, exp_tok.le));
          if (m_tuser[2] !== exp_tok.er)
            report_mismatch($sformatf("error %0b, predicted %0b", m_tuser[2], exp_tok.er));
          if (exp_tok.le && exp_tok.er) err_cnt++;
        end
      end
      if (end_of_test && !leftover_done) begin
        leftover_done = 1'b1;
        if (expected_tokens.size() != 0)
          report_mismatch($sformatf("%0d predicted tokens never came out",
                                    expected_tokens.size()));
      end
    end
    fail_count  <= mismatches;
    pending     <= expected_tokens.size();
    tokens_seen <= tok_cnt;
    error_lines <= err_cnt;
  end

endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives the shell line tokenizer with directed lines and random command
// lines (mostly well formed, some broken, some raw noise) under bursty input
// and a stalling output, and gives the verdict from the checker's count.
// ----------------------------------------------------------------------------

module testbench;

  localparam int ITEM_TARGET = 1050;
  localparam int IDLE_LIMIT  = 2000;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = 8'h00;
  logic       s_tuser = 1'b0;
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;
  logic [2:0] m_tuser;
  logic       m_tlast;
  logic       end_of_test = 1'b0;

  int fail_count;
  int pending;
  int tokens_seen;
  int error_lines;

  int items_sent = 0;
  int lines_sent = 0;
  int burst_left = 0;
  int gap_left   = 0;
  int idle_cycles = 0;

  // Receiver stall pattern state
  int rx_mode = 0;
  int rx_left = 0;
  int rx_phase = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  shell_line_tokenizer u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  slt_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .m_tlast     (m_tlast),
    .end_of_test (end_of_test),
    .fail_count  (fail_count),
    .pending     (pending),
    .tokens_seen (tokens_seen),
    .error_lines (error_lines)
  );

  // Watchdog: too long without any transfer ends the run
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t watchdog: no transfer for %0d cycles", $time, IDLE_LIMIT);
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Receiver: modes of full speed, random, sparse, periodic and hard stall
  always @(negedge clk) begin
    if (rx_left <= 0) begin
      rx_mode = $urandom_range(0, 4);
      rx_left = (rx_mode == 4) ? $urandom_range(4, 16) : $urandom_range(8, 64);
    end
    rx_left--;
    rx_phase++;
    case (rx_mode)
      0:       m_tready <= 1'b1;
      1:       m_tready <= 1'($urandom_range(0, 1));
      2:       m_tready <= ($urandom_range(0, 3) == 0);
      3:       m_tready <= (rx_phase % 5 != 0);
      default: m_tready <= 1'b0;
    endcase
  end

  // Sender: one item per call, bursts with random gaps between them
  task automatic send_item(input logic op, input logic [7:0] c);
    while (gap_left > 0) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
      gap_left--;
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= c;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
    if (op == slt_pkg::OP_EOL) lines_sent++;
    if (op == slt_pkg::OP_EOL || c != slt_pkg::CH_NUL) items_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 40);
      gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
    end
  endtask

  function automatic logic is_meta(input logic [7:0] b);
    return b == slt_pkg::CH_NUL || b == slt_pkg::CH_SPACE || b == slt_pkg::CH_TAB ||
           b == slt_pkg::CH_NL || b == slt_pkg::CH_LT || b == slt_pkg::CH_GT ||
           b == slt_pkg::CH_PIPE || b == slt_pkg::CH_SEMI ||
           b == slt_pkg::CH_LPAREN || b == slt_pkg::CH_RPAREN ||
           b == slt_pkg::CH_BSLASH || b == slt_pkg::CH_SQUOTE ||
           b == slt_pkg::CH_DQUOTE;
  endfunction

  // Ordinary word byte, any value that the lexer treats as plain
  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    b = 8'($urandom_range(1, 255));
    while (is_meta(b)) b = 8'($urandom_range(1, 255));
    return b;
  endfunction

  // Byte inside quotes that does not close them
  function automatic logic [7:0] quoted_byte(input logic [7:0] closer);
    logic [7:0] b;
    b = 8'($urandom_range(1, 255));
    while (b == closer) b = 8'($urandom_range(1, 255));
    return b;
  endfunction

  // One random command line, well formed unless the tail is broken
  task automatic gen_line();
    int         pieces;
    int         p;
    int         k;
    int         n;
    logic [7:0] b;
    pieces = $urandom_range(1, 8);
    for (p = 0; p < pieces; p++) begin
      case ($urandom_range(0, 9)) inside
        [0:2]: begin
          n = $urandom_range(1, 5);
          for (k = 0; k < n; k++) send_item(slt_pkg::OP_BYTE, plain_byte());
        end
        3: begin
          case ($urandom_range(0, 2))
            0:       b = slt_pkg::CH_SPACE;
            1:       b = slt_pkg::CH_TAB;
            default: b = slt_pkg::CH_NL;
          endcase
          send_item(slt_pkg::OP_BYTE, b);
        end
        4: begin
          case ($urandom_range(0, 3))
            0:       b = slt_pkg::CH_PIPE;
            1:       b = slt_pkg::CH_SEMI;
            2:       b = slt_pkg::CH_LPAREN;
            default: b = slt_pkg::CH_RPAREN;
          endcase
          send_item(slt_pkg::OP_BYTE, b);
        end
        5: begin
          b = $urandom_range(0, 1) ? slt_pkg::CH_LT : slt_pkg::CH_GT;
          send_item(slt_pkg::OP_BYTE, b);
          if ($urandom_range(0, 1)) send_item(slt_pkg::OP_BYTE, b);
        end
        6: begin
          send_item(slt_pkg::OP_BYTE, slt_pkg::CH_SQUOTE);
          n = $urandom_range(0, 4);
          for (k = 0; k < n; k++) begin
            send_item(slt_pkg::OP_BYTE, quoted_byte(slt_pkg::CH_SQUOTE));
          end
          send_item(slt_pkg::OP_BYTE, slt_pkg::CH_SQUOTE);
        end
        7: begin
          send_item(slt_pkg::OP_BYTE, slt_pkg::CH_DQUOTE);
          n = $urandom_range(0, 5);
          for (k = 0; k < n; k++) begin
            b = quoted_byte(slt_pkg::CH_DQUOTE);
            send_item(slt_pkg::OP_BYTE, b);
            if (b == slt_pkg::CH_BSLASH) begin
              send_item(slt_pkg::OP_BYTE, 8'($urandom_range(1, 255)));
            end
          end
          send_item(slt_pkg::OP_BYTE, slt_pkg::CH_DQUOTE);
        end
        8: begin
          send_item(slt_pkg::OP_BYTE, slt_pkg::CH_BSLASH);
          send_item(slt_pkg::OP_BYTE, 8'($urandom_range(1, 255)));
        end
        default: send_item(slt_pkg::OP_BYTE, slt_pkg::CH_NUL);
      endcase
    end
    // occasionally end on an open quote, a lone backslash or a held redirect
    if ($urandom_range(0, 7) == 0) begin
      case ($urandom_range(0, 3))
        0: begin
          send_item(slt_pkg::OP_BYTE, slt_pkg::CH_SQUOTE);
          send_item(slt_pkg::OP_BYTE, quoted_byte(slt_pkg::CH_SQUOTE));
        end
        1: begin
          send_item(slt_pkg::OP_BYTE, slt_pkg::CH_DQUOTE);
          send_item(slt_pkg::OP_BYTE, quoted_byte(slt_pkg::CH_DQUOTE));
        end
        2:       send_item(slt_pkg::OP_BYTE, slt_pkg::CH_BSLASH);
        default: send_item(slt_pkg::OP_BYTE,
                           $urandom_range(0, 1) ? slt_pkg::CH_LT : slt_pkg::CH_GT);
      endcase
    end
    send_item(slt_pkg::OP_EOL, 8'($urandom_range(0, 255)));
  endtask

  initial begin
    int n;
    int k;
    burst_left = $urandom_range(1, 40);
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: byte extremes, redirects, escapes, quotes, zero byte, line ends
    send_item(slt_pkg::OP_BYTE, 8'h01);
    send_item(slt_pkg::OP_BYTE, 8'hFF);
    send_item(slt_pkg::OP_BYTE, slt_pkg::CH_LT);
    send_item(slt_pkg::OP_BYTE, slt_pkg::CH_LT);
    send_item(slt_pkg::OP_BYTE, slt_pkg::CH_GT);
    send_item(slt_pkg::OP_BYTE, slt_pkg::CH_NUL);
    send_item(slt_pkg::OP_BYTE, 8'h78);
    send_item(slt_pkg::OP_BYTE, slt_pkg::CH_BSLASH);
    send_item(slt_pkg::OP_BYTE, slt_pkg::CH_SPACE);
    send_item(slt_pkg::OP_BYTE, slt_pkg::CH_PIPE);
    send_item(slt_pkg::OP_BYTE, slt_pkg::CH_SQUOTE);
    send_item(slt_pkg::OP_BYTE, slt_pkg::CH_BSLASH);
    send_item(slt_pkg::OP_EOL, 8'hFF);
    send_item(slt_pkg::OP_BYTE, slt_pkg::CH_DQUOTE);
    send_item(slt_pkg::OP_BYTE, slt_pkg::CH_BSLASH);
    send_item(slt_pkg::OP_BYTE, slt_pkg::CH_DQUOTE);
    send_item(slt_pkg::OP_BYTE, slt_pkg::CH_TAB);
    send_item(slt_pkg::OP_BYTE, slt_pkg::CH_DQUOTE);
    send_item(slt_pkg::OP_BYTE, slt_pkg::CH_GT);
    send_item(slt_pkg::OP_EOL, 8'h00);
    send_item(slt_pkg::OP_BYTE, slt_pkg::CH_LPAREN);
    send_item(slt_pkg::OP_BYTE, slt_pkg::CH_RPAREN);
    send_item(slt_pkg::OP_BYTE, slt_pkg::CH_SEMI);
    send_item(slt_pkg::OP_BYTE, slt_pkg::CH_BSLASH);
    send_item(slt_pkg::OP_EOL, 8'h5A);

    // Random lines, about one in six is raw noise
    while (items_sent < ITEM_TARGET) begin
      if ($urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 12);
        for (k = 0; k < n; k++) send_item(slt_pkg::OP_BYTE, 8'($urandom_range(0, 255)));
        send_item(slt_pkg::OP_EOL, 8'($urandom_range(0, 255)));
      end else begin
        gen_line();
      end
    end
    s_tvalid <= 1'b0;

    // Drain, then a few cycles for anything stray
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    @(negedge clk);
    end_of_test <= 1'b1;
    repeat (2) @(posedge clk);
    @(negedge clk);

    $display("Sent %0d lines, %0d non-ignored items; compared %0d tokens", lines_sent,
             items_sent, tokens_seen);
    $display("%0d lines ended with a quote left open", error_lines);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("simulation failed");
    end
    $finish;
  end

endmodule
